### hdl/ostl_pkg.sv
// ----------------------------------------------------------------------------
// ostl_pkg
// Shared widths, defaults and types for the one-shot timer list.
// ----------------------------------------------------------------------------
package ostl_pkg;

   localparam int TIME_W   = 32;
   localparam int HANDLE_W = 16;
   localparam int SLOTS_DEFAULT = 16;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic KIND_FIRED  = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0]   time_value;
      logic [HANDLE_W-1:0] handle;
   } cell_data_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

### hdl/one_shot_timer_list.sv
// ----------------------------------------------------------------------------
// one_shot_timer_list
// Ordered list of one-shot timers held in a row of slots that shift toward
// the head. Add appends; tick walks the list, fires and compacts.
// Add: a new request can be taken right after an add unless a reject waits for the
//   result register; the reject result shows in the cycle after the transfer when the
//   result register is free, later on stall. Tick: the walk takes one slot per
//   cycle through the head while the result side does not stall, then closes;
//   each fired handle is held until the next fire or the closing cycle.
// Synchronous reset empties the list and clears all control state.
// ----------------------------------------------------------------------------
module one_shot_timer_list #(
   parameter int SLOTS = ostl_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [ostl_pkg::TIME_W-1:0]   req_time_value,
   input  logic [ostl_pkg::HANDLE_W-1:0] req_handle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [ostl_pkg::HANDLE_W-1:0] rsp_fired_handle,
   output logic                          rsp_last
);

   localparam int CW = $clog2(SLOTS + 1);
   localparam int IW = $clog2(SLOTS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 todo_ff, todo_in;
   logic [CW-1:0]                 kept_ff, kept_in;
   logic [ostl_pkg::TIME_W-1:0]   tick_ff, tick_in;
   logic [ostl_pkg::HANDLE_W-1:0] rej_ff, rej_in;
   logic                          pend_v_ff, pend_v_in;
   logic [ostl_pkg::HANDLE_W-1:0] pend_h_ff, pend_h_in;

   logic                          rsp_valid_ff;
   logic                          rsp_kind_ff;
   logic [ostl_pkg::HANDLE_W-1:0] rsp_handle_ff;
   logic                          rsp_last_ff;

   logic                          push;
   logic                          push_kind;
   logic [ostl_pkg::HANDLE_W-1:0] push_handle;
   logic                          push_last;

   logic                          shift_en;
   logic                          load_en;
   logic [IW-1:0]                 load_idx;
   ostl_pkg::cell_data_type       load_data;

   ostl_pkg::cell_data_type       cell_q [SLOTS];
   ostl_pkg::cell_data_type       head;
   logic                          fire;
   logic                          out_free;
   logic [CW-1:0]                 wr_pos;

   assign head     = cell_q[0];
   assign fire     = head.time_value <= tick_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign wr_pos   = todo_ff + kept_ff - CW'(1);
   assign req_stall = state_ff != ST_IDLE;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      todo_in     = todo_ff;
      kept_in     = kept_ff;
      tick_in     = tick_ff;
      rej_in      = rej_ff;
      pend_v_in   = pend_v_ff;
      pend_h_in   = pend_h_ff;
      push        = 1'b0;
      push_kind   = ostl_pkg::KIND_FIRED;
      push_handle = pend_h_ff;
      push_last   = 1'b0;
      shift_en    = 1'b0;
      load_en     = 1'b0;
      load_idx    = count_ff[IW-1:0];
      load_data.time_value = req_time_value;
      load_data.handle     = req_handle;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == ostl_pkg::OP_TICK) begin
                  tick_in  = req_time_value;
                  todo_in  = count_ff;
                  kept_in  = '0;
                  state_in = ST_WALK;
               end else if (count_ff < CW'(SLOTS)) begin
                  load_en  = 1'b1;
                  count_in = count_ff + CW'(1);
               end else if (out_free) begin
                  push        = 1'b1;
                  push_kind   = ostl_pkg::KIND_REJECT;
                  push_handle = req_handle;
                  push_last   = 1'b1;
               end else begin
                  rej_in   = req_handle;
                  state_in = ST_REJECT;
               end
            end
         end
         ST_REJECT: begin
            if (out_free) begin
               push        = 1'b1;
               push_kind   = ostl_pkg::KIND_REJECT;
               push_handle = rej_ff;
               push_last   = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (todo_ff != '0) begin
               if (!fire) begin
                  shift_en = 1'b1;
                  load_en  = 1'b1;
                  load_idx = wr_pos[IW-1:0];
                  load_data.time_value = head.time_value - tick_ff;
                  load_data.handle     = head.handle;
                  todo_in  = todo_ff - CW'(1);
                  kept_in  = kept_ff + CW'(1);
               end else if (!pend_v_ff || out_free) begin
                  shift_en  = 1'b1;
                  todo_in   = todo_ff - CW'(1);
                  push      = pend_v_ff;
                  pend_v_in = 1'b1;
                  pend_h_in = head.handle;
               end
            end else if (!pend_v_ff) begin
               count_in = kept_ff;
               state_in = ST_IDLE;
            end else if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               pend_v_in = 1'b0;
               count_in  = kept_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         todo_ff      <= '0;
         kept_ff      <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         todo_ff   <= todo_in;
         kept_ff   <= kept_in;
         pend_v_ff <= pend_v_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tick_ff   <= tick_in;
      rej_ff    <= rej_in;
      pend_h_ff <= pend_h_in;
      if (push) begin
         rsp_kind_ff   <= push_kind;
         rsp_handle_ff <= push_handle;
         rsp_last_ff   <= push_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_fired_handle = rsp_handle_ff;
   assign rsp_last         = rsp_last_ff;

   // slot row; slot 0 is the head of the list
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ostl_pkg::cell_ctrl_type ctrl;
      ostl_pkg::cell_data_type next_data;

      assign ctrl.shift = shift_en;
      assign ctrl.load  = load_en && (load_idx == IW'(i));

      if (i == SLOTS - 1) begin : g_tail
         assign next_data = cell_q[i];
      end else begin : g_body
         assign next_data = cell_q[i+1];
      end

      ostl_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_data (load_data),
         .next_data (next_data),
         .data_q    (cell_q[i])
      );
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS))
      else $error("timer count above capacity");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ({1'b0, todo_ff} + {1'b0, kept_ff} <= {1'b0, count_ff}))
      else $error("walk counters exceed list length");

   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_v_ff |-> (state_ff == ST_WALK))
      else $error("pending fired handle outside a tick walk");

   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == ostl_pkg::KIND_REJECT) |-> rsp_last_ff)
      else $error("reject result without last");

   a_walk_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && todo_ff == '0 && !pend_v_ff) |=>
         (state_ff == ST_IDLE && count_ff == $past(kept_ff)))
      else $error("tick walk did not close with survivor count");

endmodule

### hdl/ostl_cell.sv
// ----------------------------------------------------------------------------
// ostl_cell
// One timer slot: loads a new entry or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module ostl_cell (
   input  logic                    clock,
   input  ostl_pkg::cell_ctrl_type ctrl,
   input  ostl_pkg::cell_data_type load_data,
   input  ostl_pkg::cell_data_type next_data,
   output ostl_pkg::cell_data_type data_q
);

   ostl_pkg::cell_data_type data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         data_ff <= load_data;
      end else if (ctrl.shift) begin
         data_ff <= next_data;
      end
   end

   assign data_q = data_ff;

endmodule
